@@ src/mss_pkg.sv @@
// shared types, constants and helpers for the mux sensor scan sequencer
// no dependencies; every other file refers to it by scoped names
package mss_pkg;

  // default timestamp arithmetic width
  localparam int TIME_BITS_DEF = 40;

  // field widths
  localparam int FUNC_W   = 2;
  localparam int SAMPLE_W = 12;
  localparam int NOW_W    = 40;
  localparam int CHAN_W   = 4;
  localparam int SLOT_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int PKT_W    = 16;
  localparam int PHASE_W  = 2;
  localparam int WDOG_W   = 8;
  localparam int THR_W    = 12;
  localparam int TMO_W    = 20;
  localparam int MAP_W    = 36;
  localparam int NIB_W    = 4;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_THR  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TMO  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WDOG = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PLIM = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAP  = 3'd4;

  // register reset values
  localparam logic [THR_W-1:0]  THR_RST  = 12'd2046;
  localparam logic [TMO_W-1:0]  TMO_RST  = 20'd30050;
  localparam logic [WDOG_W-1:0] WDOG_RST = 8'd50;
  localparam logic [PKT_W-1:0]  PLIM_RST = 16'd50;
  localparam logic [MAP_W-1:0]  MAP_RST  = 36'd0;

  // function codes of an input beat
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POLL  = 2'd2;

  // echo measurement phases
  localparam logic [PHASE_W-1:0] PH_TRIG = 2'd0;
  localparam logic [PHASE_W-1:0] PH_LOW  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_RISE = 2'd2;
  localparam logic [PHASE_W-1:0] PH_HIGH = 2'd3;

  // packet slots
  localparam logic [SLOT_W-1:0] SLOT_LAST_RANGER = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_IR_FRONT    = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_IR_LEFT     = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_BATT        = 3'd5;

  // channel map nibbles
  localparam logic [NIB_W-1:0] NIB_IR_FRONT = 4'd6;
  localparam logic [NIB_W-1:0] NIB_IR_LEFT  = 4'd7;
  localparam logic [NIB_W-1:0] NIB_BATT     = 4'd8;

  localparam logic [VALUE_W-1:0] VALUE_SAT = '1;
  localparam logic [PKT_W-1:0]   PKT_MAX   = '1;

  typedef struct packed {
    logic [THR_W-1:0]  echo_threshold;
    logic [TMO_W-1:0]  echo_timeout_us;
    logic [WDOG_W-1:0] watchdog_limit;
    logic [PKT_W-1:0]  packet_limit;
    logic [MAP_W-1:0]  channel_map;
  } cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [SAMPLE_W-1:0] analog_sample;
    logic                digital_level;
    logic [NOW_W-1:0]    now_us;
  } item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  mux_channel;
    logic               drive_line;
    logic               fire_trigger;
    logic               value_valid;
    logic [SLOT_W-1:0]  value_slot;
    logic [VALUE_W-1:0] value;
    logic [PKT_W-1:0]   packet_tally;
    logic               scanning;
  } result_t;

  // mux channel held in nibble nib of the channel map
  function automatic logic [CHAN_W-1:0] chan_of(input logic [MAP_W-1:0] map,
                                                input logic [NIB_W-1:0] nib);
    return map[{nib, 2'b00} +: CHAN_W];
  endfunction

endpackage

@@ src/mss_ifs.sv @@
// valid/ready channel interfaces for sample polls and scan results
// depends on mss_pkg for field widths
interface mss_in_if;
  logic                           valid;
  logic                           ready;
  logic [mss_pkg::FUNC_W-1:0]     func;
  logic [mss_pkg::SAMPLE_W-1:0]   analog_sample;
  logic                           digital_level;
  logic [mss_pkg::NOW_W-1:0]      now_us;

  modport source (output valid, func, analog_sample, digital_level, now_us,
                  input ready);
  modport sink (input valid, func, analog_sample, digital_level, now_us,
                output ready);
endinterface

interface mss_out_if;
  logic                           valid;
  logic                           ready;
  logic [mss_pkg::CHAN_W-1:0]     mux_channel;
  logic                           drive_line;
  logic                           fire_trigger;
  logic                           value_valid;
  logic [mss_pkg::SLOT_W-1:0]     value_slot;
  logic [mss_pkg::VALUE_W-1:0]    value;
  logic [mss_pkg::PKT_W-1:0]      packet_tally;
  logic                           scanning;

  modport source (output valid, mux_channel, drive_line, fire_trigger, value_valid,
                  value_slot, value, packet_tally, scanning,
                  input ready);
  modport sink (input valid, mux_channel, drive_line, fire_trigger, value_valid,
                value_slot, value, packet_tally, scanning,
                output ready);
endinterface

@@ src/mss_cfg.sv @@
// apb-style configuration register file
// depends on mss_pkg for register indexes, reset values and cfg_t
module mss_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mss_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [mss_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [mss_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output mss_pkg::cfg_t                     cfg
);

  mss_pkg::cfg_t                   cfg_r;
  logic                            wr_en;
  logic [mss_pkg::REG_IDX_W-1:0]   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  // registers sit on 8-byte boundaries
  assign idx    = paddr[mss_pkg::CFG_ADDR_W-1:3];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.echo_threshold  <= mss_pkg::THR_RST;
      cfg_r.echo_timeout_us <= mss_pkg::TMO_RST;
      cfg_r.watchdog_limit  <= mss_pkg::WDOG_RST;
      cfg_r.packet_limit    <= mss_pkg::PLIM_RST;
      cfg_r.channel_map     <= mss_pkg::MAP_RST;
    end else if (wr_en) begin
      case (idx)
        mss_pkg::REG_THR:  cfg_r.echo_threshold  <= pwdata[mss_pkg::THR_W-1:0];
        mss_pkg::REG_TMO:  cfg_r.echo_timeout_us <= pwdata[mss_pkg::TMO_W-1:0];
        mss_pkg::REG_WDOG: cfg_r.watchdog_limit  <= pwdata[mss_pkg::WDOG_W-1:0];
        mss_pkg::REG_PLIM: cfg_r.packet_limit    <= pwdata[mss_pkg::PKT_W-1:0];
        mss_pkg::REG_MAP:  cfg_r.channel_map     <= pwdata[mss_pkg::MAP_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      mss_pkg::REG_THR:  prdata = mss_pkg::CFG_DATA_W'(cfg_r.echo_threshold);
      mss_pkg::REG_TMO:  prdata = mss_pkg::CFG_DATA_W'(cfg_r.echo_timeout_us);
      mss_pkg::REG_WDOG: prdata = mss_pkg::CFG_DATA_W'(cfg_r.watchdog_limit);
      mss_pkg::REG_PLIM: prdata = mss_pkg::CFG_DATA_W'(cfg_r.packet_limit);
      mss_pkg::REG_MAP:  prdata = mss_pkg::CFG_DATA_W'(cfg_r.channel_map);
      default:           prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ src/mss_step.sv @@
// scan state registers and the single-pass step logic for one input beat
// depends on mss_pkg for item_t, result_t, cfg_t, codes and chan_of
module mss_step #(
  parameter int TIME_BITS = mss_pkg::TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  mss_pkg::item_t    item,
  input  mss_pkg::cfg_t     cfg,
  output mss_pkg::result_t  res
);

  logic                          run_r, run_nxt;
  logic [mss_pkg::SLOT_W-1:0]    slot_r, slot_nxt;
  logic [mss_pkg::PHASE_W-1:0]   phase_r, phase_nxt;
  logic [mss_pkg::WDOG_W-1:0]    wait_r, wait_nxt;
  logic [TIME_BITS-1:0]          rise_r, rise_nxt;
  logic [mss_pkg::PKT_W-1:0]     pkt_r, pkt_nxt;

  logic [63:0]                   now64;
  logic [TIME_BITS-1:0]          now_w;
  logic [TIME_BITS-1:0]          elapsed;
  logic [63:0]                   el64;
  logic [mss_pkg::VALUE_W-1:0]   el_sat;
  logic                          el_over;
  logic [mss_pkg::WDOG_W:0]      cnt;
  logic                          wd_over;
  logic                          samp_lo, samp_hi;
  logic [mss_pkg::NIB_W-1:0]     trig_nib, echo_nib;

  // timestamp taken modulo 2^TIME_BITS, pulse width and its saturation
  assign now64   = 64'(item.now_us);
  assign now_w   = now64[TIME_BITS-1:0];
  assign elapsed = now_w - rise_r;
  assign el64    = 64'(elapsed);
  assign el_over = el64 > 64'(cfg.echo_timeout_us);
  assign el_sat  = (|el64[63:mss_pkg::VALUE_W]) ? mss_pkg::VALUE_SAT
                                                : el64[mss_pkg::VALUE_W-1:0];

  // watchdog and threshold compares
  assign cnt     = {1'b0, wait_r} + 9'd1;
  assign wd_over = cnt > {1'b0, cfg.watchdog_limit};
  assign samp_lo = item.analog_sample < cfg.echo_threshold;
  assign samp_hi = item.analog_sample > cfg.echo_threshold;

  // ranger nibbles: trigger at 2*slot, echo right after it
  assign trig_nib = {1'b0, slot_r[1:0], 1'b0};
  assign echo_nib = {1'b0, slot_r[1:0], 1'b1};

  // next state and result of one beat
  always_comb begin
    run_nxt   = run_r;
    slot_nxt  = slot_r;
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    rise_nxt  = rise_r;
    pkt_nxt   = pkt_r;
    res       = '0;

    case (item.func)
      mss_pkg::FUNC_START: begin
        if (!run_r) begin
          run_nxt   = 1'b1;
          slot_nxt  = '0;
          phase_nxt = mss_pkg::PH_TRIG;
          wait_nxt  = '0;
        end
      end
      mss_pkg::FUNC_STOP: begin
        run_nxt   = 1'b0;
        slot_nxt  = '0;
        phase_nxt = mss_pkg::PH_TRIG;
        wait_nxt  = '0;
      end
      mss_pkg::FUNC_POLL: begin
        if (run_r) begin
          if (pkt_r == cfg.packet_limit) begin
            // limit reached: halt without sampling
            run_nxt   = 1'b0;
            slot_nxt  = '0;
            phase_nxt = mss_pkg::PH_TRIG;
            wait_nxt  = '0;
          end else if (slot_r <= mss_pkg::SLOT_LAST_RANGER) begin
            if (phase_r == mss_pkg::PH_TRIG) begin
              res.mux_channel  = mss_pkg::chan_of(cfg.channel_map, trig_nib);
              res.drive_line   = 1'b1;
              res.fire_trigger = 1'b1;
              phase_nxt        = mss_pkg::PH_LOW;
            end else begin
              res.mux_channel = mss_pkg::chan_of(cfg.channel_map, echo_nib);
              case (phase_r)
                mss_pkg::PH_LOW: begin
                  if (samp_lo) phase_nxt = mss_pkg::PH_RISE;
                end
                mss_pkg::PH_RISE: begin
                  if (samp_hi) begin
                    rise_nxt  = now_w;
                    phase_nxt = mss_pkg::PH_HIGH;
                  end
                  // watchdog wins over a rise seen in the same poll
                  if (wd_over) begin
                    res.value_valid = 1'b1;
                    res.value_slot  = slot_r;
                    res.value       = '0;
                    slot_nxt        = slot_r + 3'd1;
                    phase_nxt       = mss_pkg::PH_TRIG;
                    wait_nxt        = '0;
                  end else begin
                    wait_nxt = cnt[mss_pkg::WDOG_W-1:0];
                  end
                end
                default: begin
                  // timing the high pulse
                  if (el_over || samp_lo) begin
                    res.value_valid = 1'b1;
                    res.value_slot  = slot_r;
                    res.value       = el_sat;
                    slot_nxt        = slot_r + 3'd1;
                    phase_nxt       = mss_pkg::PH_TRIG;
                    wait_nxt        = '0;
                  end
                end
              endcase
            end
          end else if (slot_r <= mss_pkg::SLOT_IR_LEFT) begin
            res.mux_channel = mss_pkg::chan_of(cfg.channel_map,
                                (slot_r == mss_pkg::SLOT_IR_FRONT) ? mss_pkg::NIB_IR_FRONT
                                                                    : mss_pkg::NIB_IR_LEFT);
            res.value_valid = 1'b1;
            res.value_slot  = slot_r;
            res.value       = mss_pkg::VALUE_W'(item.digital_level);
            slot_nxt        = slot_r + 3'd1;
            phase_nxt       = mss_pkg::PH_TRIG;
            wait_nxt        = '0;
          end else if (slot_r == mss_pkg::SLOT_BATT) begin
            res.mux_channel = mss_pkg::chan_of(cfg.channel_map, mss_pkg::NIB_BATT);
            res.value_valid = 1'b1;
            res.value_slot  = slot_r;
            res.value       = mss_pkg::VALUE_W'(item.analog_sample);
            slot_nxt        = slot_r + 3'd1;
            phase_nxt       = mss_pkg::PH_TRIG;
            wait_nxt        = '0;
          end else begin
            // packet close, also taken for the spare slot code
            if (pkt_r != mss_pkg::PKT_MAX) pkt_nxt = pkt_r + 16'd1;
            slot_nxt  = '0;
            phase_nxt = mss_pkg::PH_TRIG;
            wait_nxt  = '0;
          end
        end
      end
      default: ;
    endcase

    res.packet_tally = pkt_nxt;
    res.scanning     = run_nxt;
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      slot_r  <= '0;
      phase_r <= mss_pkg::PH_TRIG;
      wait_r  <= '0;
      rise_r  <= '0;
      pkt_r   <= '0;
    end else if (adv) begin
      run_r   <= run_nxt;
      slot_r  <= slot_nxt;
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      rise_r  <= rise_nxt;
      pkt_r   <= pkt_nxt;
    end
  end

endmodule

@@ src/mux_sensor_scan_sequencer_unit.sv @@
// top level of the mux sensor scan sequencer: input register, step logic, result register
// depends on mss_pkg, mss_ifs (mss_in_if, mss_out_if), mss_cfg and mss_step
//
//  channel  | direction | beat contents
//  ---------+-----------+-----------------------------------------------------------
//  in_ch    | in        | func, analog_sample, digital_level, now_us
//  out_ch   | out       | mux_channel, drive_line, fire_trigger, value_valid,
//           |           | value_slot, value, packet_tally, scanning
//  apb      | in        | register writes/reads, 8-byte stride, 64-bit data
//
// one beat per cycle sustained while out_ch.ready stays high; every input beat gives exactly one result beat
// path: input register, then step logic into the result register
// a stalled result register holds; one more beat waits in the input register
// synchronous active-low reset stops the scan and loads register defaults
module mux_sensor_scan_sequencer_unit #(
  parameter int TIME_BITS = mss_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mss_in_if.sink                            in_ch,
  mss_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mss_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [mss_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [mss_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  mss_pkg::cfg_t     cfg;
  mss_pkg::item_t    item_r;
  mss_pkg::result_t  res, res_r;
  logic              in_vld_r, in_vld_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              in_acc;
  logic              adv;

  // configuration registers
  mss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake: step fires when the result register is free or draining
  assign adv         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_vld_nxt  = in_acc || (in_vld_r && !adv);
  assign out_vld_nxt = adv || (out_vld_r && !out_ch.ready);

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // input beat register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.func          <= in_ch.func;
      item_r.analog_sample <= in_ch.analog_sample;
      item_r.digital_level <= in_ch.digital_level;
      item_r.now_us        <= in_ch.now_us;
    end
  end

  // step logic and scan state
  mss_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (adv) res_r <= res;
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.mux_channel  = res_r.mux_channel;
  assign out_ch.drive_line   = res_r.drive_line;
  assign out_ch.fire_trigger = res_r.fire_trigger;
  assign out_ch.value_valid  = res_r.value_valid;
  assign out_ch.value_slot   = res_r.value_slot;
  assign out_ch.value        = res_r.value;
  assign out_ch.packet_tally = res_r.packet_tally;
  assign out_ch.scanning     = res_r.scanning;

`ifndef NO_ASSERTIONS
  // input side only stalls behind a full, stalled result register
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_vld_r && out_vld_r && !out_ch.ready))
    else $error("input stalled without a stalled result");

  // a stop beat always leaves the scan stopped and writes no slot
  a_stop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && item_r.func == mss_pkg::FUNC_STOP) |=>
      (out_vld_r && !res_r.scanning && !res_r.value_valid))
    else $error("stop beat did not stop the scan");

  // a stopped scan never samples or fires
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !res_r.scanning) |-> (!res_r.value_valid && !res_r.fire_trigger))
    else $error("activity while not scanning");

  // trigger step drives the line and writes no slot value
  a_trig_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.fire_trigger) |-> (res_r.drive_line && !res_r.value_valid))
    else $error("trigger without drive or with value");
`endif

endmodule
